// ===== design/lipr_pkg.sv =====
// Shared types and constants for the linear interpolation pitch resampler.
// No dependencies; every design file imports this package.
`default_nettype none
package lipr_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int STEP_W      = 17;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int POS_INT_W   = $clog2(MAX_SAMPLES + 2);
  localparam int POS_W       = POS_INT_W + FRAC_W;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int NUM_W       = PROD_W + 1;

  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(65536);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_PAD    = 1'b1
  } cmd_t;

  // One output job: result = a + (b - a) * frac / 2^16, truncated toward zero.
  // Pad outputs travel as a = b = frac = 0.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic        [FRAC_W-1:0]   frac;
    logic                       last;
  } job_t;

endpackage
`default_nettype wire

// ===== design/lipr_front.sv =====
// Front end: accepts commands, tracks read position and counts, issues jobs.
// Depends on lipr_pkg.
`default_nettype none
module lipr_front import lipr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [STEP_W-1:0]   cfg_data,
  input  wire logic                in_valid,
  input  wire logic                in_cmd,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                in_last,
  input  wire logic                q_full,
  output logic                     in_ready,
  output logic                     q_push,
  output job_t                     q_job
);

  logic [STEP_W-1:0]          phase_step;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic [POS_W-1:0]           read_position;
  logic [CNT_W-1:0]           samples_received;
  logic [CNT_W-1:0]           samples_emitted;
  logic                       input_finished;

  logic                       take;
  cmd_t                       cmd;
  logic [CNT_W-1:0]           j_prev;
  logic [CNT_W-1:0]           j_next;
  logic [CNT_W-1:0]           emitted_next;
  logic                       hit;
  logic                       pad_last;
  logic [STEP_W-1:0]          step;

  assign in_ready     = !q_full;
  assign take         = in_valid && in_ready;
  assign cmd          = cmd_t'(in_cmd);
  assign j_prev       = samples_received - CNT_W'(1);
  assign j_next       = samples_received + CNT_W'(1);
  assign emitted_next = samples_emitted + CNT_W'(1);
  assign step         = phase_step[STEP_W-1] ? phase_step : STEP_ONE;
  assign hit          = (samples_received != '0) &&
                        (read_position[POS_W-1:FRAC_W] == POS_INT_W'(j_prev));
  assign pad_last     = emitted_next >= samples_received;

  always_comb begin
    q_push = 1'b0;
    q_job  = '0;
    if (take) begin
      unique case (cmd)
        CMD_SAMPLE: begin
          if (!input_finished && hit) begin
            q_push     = 1'b1;
            q_job.a    = previous_sample;
            q_job.b    = $signed(in_sample);
            q_job.frac = read_position[FRAC_W-1:0];
          end
        end
        CMD_PAD: begin
          if (input_finished) begin
            q_push     = 1'b1;
            q_job.last = pad_last;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= STEP_ONE;
      previous_sample  <= '0;
      read_position    <= '0;
      samples_received <= '0;
      samples_emitted  <= '0;
      input_finished   <= 1'b0;
    end else begin
      if (cfg_we) phase_step <= cfg_data;
      if (take) begin
        unique case (cmd)
          CMD_SAMPLE: begin
            if (!input_finished) begin
              samples_received <= j_next;
              previous_sample  <= $signed(in_sample);
              if (hit) begin
                samples_emitted <= emitted_next;
                read_position   <= read_position + POS_W'(step);
              end
              if (in_last || (j_next >= CNT_W'(MAX_SAMPLES))) input_finished <= 1'b1;
            end
          end
          CMD_PAD: begin
            if (input_finished) begin
              if (pad_last) begin
                previous_sample  <= '0;
                read_position    <= '0;
                samples_received <= '0;
                samples_emitted  <= '0;
                input_finished   <= 1'b0;
              end else begin
                samples_emitted <= emitted_next;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lipr_queue.sv =====
// Short register FIFO of jobs between the front end and the arithmetic back end.
// Depends on lipr_pkg.
`default_nettype none
module lipr_queue import lipr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

// ===== design/lipr_back.sv =====
// Back end: multiply stage, then add-and-truncate into the output register.
// Depends on lipr_pkg.
`default_nettype none
module lipr_back import lipr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  job_t                     q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      out_data,
  output logic                     out_last
);

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_a;
  logic signed [PROD_W-1:0]   s1_prod;
  logic                       s1_last;

  logic                       load_out;
  logic                       load_s1;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   frac_s;
  logic signed [NUM_W-1:0]    num;
  logic signed [NUM_W-1:0]    biased;

  assign load_out = !out_valid || out_ready;
  assign load_s1  = !s1_valid || load_out;
  assign q_pop    = q_valid && load_s1;

  assign diff   = $signed({q_head.b[SAMPLE_W-1], q_head.b}) -
                  $signed({q_head.a[SAMPLE_W-1], q_head.a});
  assign frac_s = $signed({1'b0, q_head.frac});

  // Truncate toward zero: bias negative sums by 2^16 - 1 before the shift.
  assign num    = $signed({{(NUM_W-SAMPLE_W-FRAC_W){s1_a[SAMPLE_W-1]}}, s1_a, FRAC_W'(0)}) +
                  $signed({s1_prod[PROD_W-1], s1_prod});
  assign biased = num[NUM_W-1] ? num + NUM_W'(65535) : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_s1)  s1_valid  <= q_valid;
      if (load_out) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_a    <= q_head.a;
      s1_prod <= diff * frac_s;
      s1_last <= q_head.last;
    end
    if (s1_valid && load_out) begin
      out_data <= biased[FRAC_W+SAMPLE_W-1:FRAC_W];
      out_last <= s1_last;
    end
  end

endmodule
`default_nettype wire

// ===== design/linear_interp_pitch_resampler.sv =====
// Top level of the linear interpolation pitch resampler.
// Depends on lipr_pkg, lipr_front, lipr_queue and lipr_back.
`default_nettype none
// The block takes one request per clock on the slave stream and returns one
// interpolated sample per clock on the master stream while the sink keeps up.
// A request is a sample (tuser 0, tlast marks the end of the block) or a pad
// tick (tuser 1). The front end decides in the accepting cycle whether a
// request yields an output, so a dropped request costs only its acceptance.
// Jobs cross a four-entry queue into the back end, whose 17x17 multiply
// stage and add/truncate output register each register the result in turn
// before it is offered on the master side. s_tready drops only when the
// queue is full, which needs a stalled master side. phase_step is written
// through cfg_we/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. It applies from the next
// position advance; values below 1.0 act as 1.0.
module linear_interp_pitch_resampler import lipr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [STEP_W-1:0]   cfg_data,   // phase_step, unsigned Q1.16
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [SAMPLE_W-1:0] s_tdata,    // [15:0] sample_in
  input  wire logic                s_tuser,    // [0] command
  input  wire logic                s_tlast,    // last_in
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [SAMPLE_W-1:0]      m_tdata,    // [15:0] sample_out
  output logic                     m_tlast     // last_out
);

  logic q_push;
  job_t q_job;
  logic q_full;
  logic q_valid;
  job_t q_head;
  logic q_pop;

  // Classify each request and hold the block position and counts.
  lipr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser),
    .in_sample (s_tdata),
    .in_last   (s_tlast),
    .q_full    (q_full),
    .in_ready  (s_tready),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // Decouple the two halves so a stalled sink does not stall the front at once.
  lipr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Interpolate and hold the result until the sink takes it.
  lipr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== design/lipr_checker.sv =====
// Port-level checks for the linear interpolation pitch resampler, bound to it.
// Depends on lipr_pkg and linear_interp_pitch_resampler.
`default_nettype none
module lipr_checker import lipr_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [SAMPLE_W-1:0] m_tdata,
  input wire logic                m_tlast
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // The block-completing output is always a pad zero.
  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == '0)
    else $error("last output not zero");

  // Backpressure on the input only follows a stalled output.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output stall");

endmodule

bind linear_interp_pitch_resampler lipr_checker u_lipr_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for linear_interp_pitch_resampler: stream stimulus, a
// scoreboard class that predicts every output sample, and per-cycle handshake idling.
// Depends on lipr_pkg and the design files under design/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lipr_pkg::*;

  localparam int STALL_LIMIT     = 1000;  // cycles without any handshake before giving up
  localparam int SETTLE_CYCLES   = 8;     // pause before a phase_step write
  localparam int DRAIN_CYCLES    = 16;    // watch for stray outputs at the end
  localparam int ITEMS_PER_PHASE = 240;
  localparam int MAX_REPORTS     = 100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } out_sample_t;

  // Scoreboard: tracks the resampler's block state and queues the output samples it owes.
  class resample_checker;
    logic [STEP_W-1:0]          step;
    logic signed [SAMPLE_W-1:0] prev;
    logic [POS_W-1:0]           pos;
    int                         received;
    int                         emitted;
    bit                         finished;
    int                         errors;
    out_sample_t                due_samples[$];

    function new();
      step   = STEP_ONE;
      errors = 0;
      clear_block();
    endfunction

    function void clear_block();
      prev     = '0;
      pos      = '0;
      received = 0;
      emitted  = 0;
      finished = 1'b0;
    endfunction

    function void write_step(logic [STEP_W-1:0] value);
      step = value;
    endfunction

    // Would this request produce an output, or is it one the block drops?
    function bit takes_effect(cmd_t cmd);
      return (cmd == CMD_SAMPLE) ? !finished : finished;
    endfunction

    function void note_request(cmd_t cmd, logic [SAMPLE_W-1:0] data, logic last_in);
      longint      a;
      longint      b;
      longint      num;
      out_sample_t o;
      if (cmd == CMD_SAMPLE) begin
        if (finished) return;
        if (received >= 1 && int'(pos[POS_W-1:FRAC_W]) == received - 1) begin
          a   = longint'(prev);
          b   = longint'($signed(data));
          num = a * 65536 + (b - a) * longint'(pos[FRAC_W-1:0]);
          // signed division truncates toward zero
          o.sample = SAMPLE_W'(num / 65536);
          o.last   = 1'b0;
          due_samples.push_back(o);
          emitted++;
          pos = pos + POS_W'((step < STEP_ONE) ? STEP_ONE : step);
        end
        received++;
        prev = data;
        if (last_in || received >= MAX_SAMPLES) finished = 1'b1;
      end else if (finished) begin
        emitted++;
        o.sample = '0;
        o.last   = (emitted >= received);
        due_samples.push_back(o);
        if (o.last) clear_block();
      end
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] data, logic last_out);
      out_sample_t want;
      if (due_samples.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: output with nothing expected: expected none, actual %0d last %0b",
                   $time, $signed(data), last_out);
        return;
      end
      want = due_samples.pop_front();
      if (data !== want.sample) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: sample_out mismatch: expected %0d, actual %0d",
                   $time, $signed(want.sample), $signed(data));
      end
      if (last_out !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: last_out mismatch: expected %0b, actual %0b",
                   $time, want.last, last_out);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [STEP_W-1:0]   cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;    // [15:0] sample_in
  logic                s_tuser;    // [0] command
  logic                s_tlast;    // last_in
  logic                m_tvalid;
  logic                m_tready;
  logic [SAMPLE_W-1:0] m_tdata;    // [15:0] sample_out
  logic                m_tlast;    // last_out

  resample_checker sb = new();

  int idle_pct  = 0;   // chance in 100 that the sender idles a cycle
  int stall_pct = 0;   // chance in 100 that the receiver stalls a cycle
  int useful_requests = 0;
  int quiet_cycles = 0;

  linear_interp_pitch_resampler dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the master side at random; stall_pct of zero keeps tready high.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Note each accepted request before checking the output of the same edge;
  // an output always trails its request through the queue, multiply and output registers.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(cmd_t'(s_tuser), s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end
  end

  // Watchdog: end the run when neither side has moved for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until accepted. Enter and leave at a falling edge;
  // tvalid stays high on exit so back-to-back requests need no second assignment.
  task automatic send_request(cmd_t cmd, logic [SAMPLE_W-1:0] data, logic last_in);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    if (sb.takes_effect(cmd)) useful_requests++;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    s_tlast  <= last_in;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic put_sample(logic [SAMPLE_W-1:0] data, logic last_in);
    send_request(CMD_SAMPLE, data, last_in);
  endtask

  // Pad tick with random don't-care data and tlast.
  task automatic put_pad();
    send_request(CMD_PAD, SAMPLE_W'($urandom), 1'($urandom));
  endtask

  // Pad until the block completes with its tlast output.
  task automatic close_block();
    while (sb.finished) put_pad();
  endtask

  // Drop tvalid, wait until every owed output has arrived and the pipeline is quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.due_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_phase_step(logic [STEP_W-1:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    sb.write_step(value);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Extremes, steps below one (treated as one) and the full legal range.
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(7))
      0:       return STEP_ONE;
      1:       return 17'h1FFFF;
      2:       return STEP_W'($urandom_range(65535));
      default: return STEP_W'($urandom_range(131071, 65536));
    endcase
  endfunction

  // One well-formed block with random content; noisy blocks add ignored requests:
  // pad ticks before the end and samples after it.
  task automatic random_block(int n, bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(9) == 0) put_pad();
      put_sample(pick_sample(), i == n - 1);
    end
    if (noisy && $urandom_range(2) == 0) begin
      repeat ($urandom_range(3, 1)) put_sample(pick_sample(), 1'($urandom));
    end
    close_block();
  endtask

  task automatic directed_checks();
    // step of exactly one: each output repeats the previous sample
    put_pad();                       // pad tick before the end: drop
    put_sample(16'h7FFF, 1'b0);
    put_sample(16'h8000, 1'b0);
    put_sample(16'h0000, 1'b0);
    put_sample(16'hFFFF, 1'b0);
    put_sample(16'h7FFF, 1'b1);
    put_sample(16'h8000, 1'b0);      // sample after the end: drop
    close_block();

    // largest step, fractions near one across full-scale swings
    set_phase_step(17'h1FFFF);
    put_sample(16'h8000, 1'b0);
    put_sample(16'h7FFF, 1'b0);
    put_sample(16'h8000, 1'b0);
    // change the step in the middle of the block
    set_phase_step(STEP_W'(98304));
    put_sample(16'h7FFF, 1'b0);
    put_sample(16'd12345, 1'b0);
    put_sample(16'hCFC7, 1'b1);
    close_block();

    // step below one acts as one; single-sample block yields only a pad output
    set_phase_step('0);
    put_sample(16'h1234, 1'b1);
    close_block();
    put_sample(16'hA5A5, 1'b0);
    put_pad();                       // still mid-block: drop
    put_sample(16'h5A5A, 1'b0);
    put_sample(16'h8001, 1'b1);
    close_block();
  endtask

  initial begin
    int start_count;
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    m_tready = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    directed_checks();

    // Idling phases: none, sender mostly idle, receiver mostly stalled, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      case (phase)
        0: set_phase_step(17'h1FFFF);
        1: set_phase_step(STEP_ONE);
        2: set_phase_step(STEP_W'($urandom_range(65535)));
        default: set_phase_step(pick_step());
      endcase
      start_count = useful_requests;
      while (useful_requests - start_count < ITEMS_PER_PHASE) begin
        if ($urandom_range(4) == 0) set_phase_step(pick_step());
        random_block(($urandom_range(9) == 0) ? $urandom_range(120, 25) : $urandom_range(16, 1),
                     $urandom_range(3) == 0);
      end
    end

    s_tvalid <= 1'b0;
    while (sb.due_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.due_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
